/* rtl/sha256_stream_hasher_top_assert.svh */
// Assertion macros used by the checker file of the SHA-256 hasher.
`ifndef SHA256_STREAM_HASHER_TOP_ASSERT_SVH
`define SHA256_STREAM_HASHER_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define SHS_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// Implication checked in the cycle after the antecedent.
`define SHS_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

/* rtl/shs_pkg.sv */
// ----------------------------------------------------------------------------
// shs_pkg
// Types, constants and round functions of the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package shs_pkg;
  localparam int QUEUE_DEPTH = 4;
  localparam logic [60:0] COUNT_MAX = {61{1'b1}};
  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       eom;
  } item_t;

  typedef enum logic [2:0] {
    ST_ACCEPT,
    ST_PAD,
    ST_COMP,
    ST_FINAL,
    ST_EMIT
  } state_t;

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction
endpackage

/* rtl/shs_queue.sv */
// ----------------------------------------------------------------------------
// shs_queue
// Short queue that parts the byte front end from the hashing engine.
// ----------------------------------------------------------------------------
module shs_queue #(
  parameter int DEPTH = shs_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  shs_pkg::item_t  wr_item,
  output logic            rd_valid,
  input  logic            rd_ready,
  output shs_pkg::item_t  rd_item
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  shs_pkg::item_t mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic wr_en, rd_en;

  assign wr_ready = (cnt_r != (AW+1)'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_item  = mem_r[rp_r];
  assign wr_en = wr_valid && wr_ready;
  assign rd_en = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) begin
        wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      end
      if (rd_en) begin
        rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (AW+1)'(wr_en) - (AW+1)'(rd_en);
    end
  end
endmodule

/* rtl/shs_engine.sv */
// ----------------------------------------------------------------------------
// shs_engine
// Block builder, padding sequencer and one-round-per-cycle compression.
// ----------------------------------------------------------------------------
module shs_engine (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           item_valid,
  output logic           item_ready,
  input  shs_pkg::item_t item,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [31:0]    out_word,
  output logic [2:0]     out_index,
  output logic           out_last
);
  shs_pkg::state_t state_r, state_nxt;
  logic [31:0] h_r [8];
  logic [31:0] v_r [8];
  logic [31:0] w_r [16];
  logic [31:0] blk_r [16];
  logic [60:0] cnt_r;
  logic [5:0]  fill_r;
  logic [5:0]  pad_r;
  logic [5:0]  rnd_r;
  logic [2:0]  emit_r;
  logic        fin_r, two_r;
  logic        pend_eom_r;
  logic        take, load, start_comp, wr_blk;
  logic [5:0]  wr_addr;
  logic [7:0]  wr_data;
  logic [31:0] t1, t2, wnew, wcur;
  logic [63:0] bits;
  logic        comp_done;

  assign bits = {cnt_r, 3'b000};
  assign item_ready = (state_r == shs_pkg::ST_ACCEPT);
  assign take = item_valid && item_ready;
  assign wcur = w_r[0];
  assign wnew = shs_pkg::ssig1(w_r[14]) + w_r[9] + shs_pkg::ssig0(w_r[1]) + w_r[0];
  assign t1 = v_r[7] + shs_pkg::bsig1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
              + shs_pkg::ROUND_K[rnd_r] + wcur;
  assign t2 = shs_pkg::bsig0(v_r[0])
              + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  assign comp_done = (state_r == shs_pkg::ST_COMP) && (rnd_r == 6'd63);
  assign out_valid = (state_r == shs_pkg::ST_EMIT);
  assign out_word  = h_r[emit_r];
  assign out_index = emit_r;
  assign out_last  = (emit_r == 3'd7);

  always_comb begin
    state_nxt = state_r;
    wr_blk = 1'b0;
    wr_addr = fill_r;
    wr_data = item.data;
    start_comp = 1'b0;
    load = 1'b0;
    case (state_r)
      shs_pkg::ST_ACCEPT: begin
        if (take && item.valid) begin
          wr_blk = 1'b1;
          if (fill_r == 6'd63) begin
            start_comp = 1'b1;
            state_nxt = shs_pkg::ST_COMP;
          end else if (item.eom) begin
            state_nxt = shs_pkg::ST_PAD;
          end
        end else if (take && item.eom) begin
          state_nxt = shs_pkg::ST_PAD;
        end
      end
      shs_pkg::ST_PAD: begin
        wr_blk = 1'b1;
        wr_addr = pad_r;
        if (pad_r == fill_r && !two_r) begin
          wr_data = shs_pkg::PAD_BYTE;
        end else if (pad_r >= 6'd56 && !(fill_r >= 6'd56 && !two_r)) begin
          wr_data = bits[8'd63 - {pad_r[2:0], 3'b000} -: 8];
        end else begin
          wr_data = 8'h00;
        end
        if (pad_r == 6'd63) begin
          start_comp = 1'b1;
          state_nxt = shs_pkg::ST_COMP;
        end
      end
      shs_pkg::ST_COMP: begin
        if (comp_done) begin
          state_nxt = shs_pkg::ST_FINAL;
        end
      end
      shs_pkg::ST_FINAL: begin
        if (fin_r && fill_r >= 6'd56 && !two_r) begin
          state_nxt = shs_pkg::ST_PAD;
        end else if (fin_r) begin
          state_nxt = shs_pkg::ST_EMIT;
        end else if (pend_eom_r) begin
          state_nxt = shs_pkg::ST_PAD;
        end else begin
          state_nxt = shs_pkg::ST_ACCEPT;
        end
      end
      shs_pkg::ST_EMIT: begin
        if (out_ready && emit_r == 3'd7) begin
          load = 1'b1;
          state_nxt = shs_pkg::ST_ACCEPT;
        end
      end
      default: state_nxt = shs_pkg::ST_ACCEPT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_blk) begin
      blk_r[wr_addr[5:2]][{~wr_addr[1:0], 3'b000} +: 8] <= wr_data;
    end
    if (start_comp) begin
      for (int i = 0; i < 8; i++) begin
        v_r[i] <= h_r[i];
      end
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= blk_r[i];
      end
      w_r[15] <= {blk_r[15][31:8], wr_data};
    end else if (state_r == shs_pkg::ST_COMP) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[15] <= wnew;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= shs_pkg::ST_ACCEPT;
      for (int i = 0; i < 8; i++) begin
        h_r[i] <= shs_pkg::INIT_HASH[i];
      end
      cnt_r <= '0;
      fill_r <= '0;
      pad_r <= '0;
      rnd_r <= '0;
      emit_r <= '0;
      fin_r <= 1'b0;
      two_r <= 1'b0;
      pend_eom_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (take && item.valid) begin
        fill_r <= fill_r + 1'b1;
        if (cnt_r != shs_pkg::COUNT_MAX) begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
      if (take) begin
        pend_eom_r <= item.eom && item.valid && fill_r == 6'd63;
        pad_r <= item.valid ? fill_r + 1'b1 : fill_r;
      end
      if (state_r == shs_pkg::ST_PAD) begin
        pad_r <= pad_r + 1'b1;
        if (start_comp) begin
          fin_r <= 1'b1;
        end
      end
      if (start_comp) begin
        rnd_r <= '0;
      end else if (state_r == shs_pkg::ST_COMP) begin
        rnd_r <= rnd_r + 1'b1;
      end
      if (state_r == shs_pkg::ST_FINAL) begin
        for (int i = 0; i < 8; i++) begin
          h_r[i] <= h_r[i] + v_r[i];
        end
        if (fin_r && fill_r >= 6'd56 && !two_r) begin
          two_r <= 1'b1;
          fin_r <= 1'b0;
          pad_r <= '0;
        end else if (!fin_r && pend_eom_r) begin
          pend_eom_r <= 1'b0;
          pad_r <= '0;
        end
      end
      if (out_valid && out_ready) begin
        emit_r <= emit_r + 1'b1;
      end
      if (load) begin
        for (int i = 0; i < 8; i++) begin
          h_r[i] <= shs_pkg::INIT_HASH[i];
        end
        cnt_r <= '0;
        fill_r <= '0;
        fin_r <= 1'b0;
        two_r <= 1'b0;
      end
    end
  end
endmodule

/* rtl/sha256_stream_hasher_top.sv */
// ----------------------------------------------------------------------------
// sha256_stream_hasher_top
// SHA-256 over a byte stream, digest returned as eight 32-bit beats.
// ----------------------------------------------------------------------------
// Bytes enter a four-beat queue at one per cycle while it has room, and the
// engine writes them into the block buffer one at a time. A full block runs
// through the single shared round unit, 64 rounds and then one fold of the
// result into the hash state, during which the queue fills and then stalls.
// An end mark adds a padding sweep over the rest of the block and one more
// compression; when the length does not fit in that block, a second sweep and
// compression follow. Eight digest beats come last.
module sha256_stream_hasher_top #(
  parameter int QUEUE_DEPTH = shs_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,  // data_byte
  input  logic        in_tuser,  // byte_valid
  input  logic        in_tlast,  // end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata, // digest_word
  output logic [2:0]  out_tuser, // word_index
  output logic        out_tlast  // last_word
);
  shs_pkg::item_t in_item, q_item;
  logic q_valid, q_ready;

  assign in_item = '{data: in_tdata, valid: in_tuser, eom: in_tlast};

  shs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(in_tvalid),
    .wr_ready(in_tready), .wr_item(in_item),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_item(q_item)
  );

  shs_engine u_engine (
    .clk(clk), .rst_n(rst_n),
    .item_valid(q_valid), .item_ready(q_ready), .item(q_item),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_word(out_tdata), .out_index(out_tuser), .out_last(out_tlast)
  );
endmodule

/* rtl/shs_checker.sv */
// ----------------------------------------------------------------------------
// shs_checker
// Port-level checks of the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
`include "sha256_stream_hasher_top_assert.svh"
module shs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [2:0]  out_tuser,
  input logic        out_tlast,
  input logic [31:0] out_tdata
);
  `SHS_ASSERT_IMP(a_last_idx, clk, rst_n, out_tvalid, out_tlast == (out_tuser == 3'd7), "last mismatch")
  `SHS_ASSERT_NEXT(a_idx_step, clk, rst_n, out_tvalid && out_tready && !out_tlast, out_tvalid && out_tuser == $past(out_tuser) + 3'd1, "index step")
  `SHS_ASSERT_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stall hold")
endmodule

bind sha256_stream_hasher_top shs_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tuser(out_tuser), .out_tlast(out_tlast), .out_tdata(out_tdata)
);
